>>> hw/rtl/pts_pkg.sv
// shared types and constants of the per-slot timeout scheduler
// depends on nothing; imported by pts_ctrl, pts_dp and the top level
`default_nettype none

package pts_pkg;

    localparam int FUNC_W    = 2;
    localparam int SLOT_F_W  = 4;
    localparam int TMO_W     = 20;
    localparam int NEAR_W    = 21;

    // most results one expire scan may emit
    localparam int RES_MAX   = 16;
    localparam int RES_IDX_W = $clog2(RES_MAX);
    localparam int RES_CNT_W = RES_IDX_W + 1;

    localparam logic [NEAR_W-2:0] NEAR_MAX  = '1;
    localparam logic [NEAR_W-1:0] NEAR_NONE = '1;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ADD    = 2'd0,
        FUNC_DEL    = 2'd1,
        FUNC_EXPIRE = 2'd2,
        FUNC_TICK   = 2'd3
    } func_t;

    typedef struct packed {
        logic accept;      // latch input transaction, clear result buffer
        logic apply;       // perform add, delete or tick
        logic scan_start;  // begin one pass over all slots
        logic take;        // disarm best due slot and queue it as a result
        logic emit_next;   // advance to next queued result
    } cmd_t;

    typedef struct packed {
        func_t func;
        logic  scan_done;
        logic  found;
        logic  buf_full;
        logic  out_last;
    } sts_t;

endpackage

`default_nettype wire

>>> hw/rtl/pts_ctrl.sv
// controller state machine of the per-slot timeout scheduler
// depends on pts_pkg; drives commands into pts_dp from its status
`default_nettype none

module pts_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  wire logic          out_ready,
    input  wire pts_pkg::sts_t sts,
    output pts_pkg::cmd_t      cmd
);
    import pts_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_EXEC = 5'b00010,
        ST_SCAN = 5'b00100,
        ST_NEAR = 5'b01000,
        ST_EMIT = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.apply      = 1'b1;
                cmd.scan_start = 1'b1;
                state_next     = (sts.func == FUNC_EXPIRE) ? ST_SCAN : ST_NEAR;
            end
            ST_SCAN:
            begin
                if (sts.scan_done)
                begin
                    if (sts.found)
                    begin
                        cmd.take       = 1'b1;
                        cmd.scan_start = 1'b1;
                        // buffer full: one more pass only for the nearest deadline
                        state_next     = sts.buf_full ? ST_NEAR : ST_SCAN;
                    end
                    else
                    begin
                        // nothing changed in this pass, its nearest value stands
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_NEAR:
            begin
                if (sts.scan_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (sts.out_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.emit_next = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/pts_dp.sv
// datapath of the per-slot timeout scheduler: time counter, pending bits,
// deadline memory, slot scan pipeline and result buffer; depends on pts_pkg
`default_nettype none

module pts_dp #(
    parameter int SLOTS     = 16,
    parameter int TIME_BITS = 32
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic [pts_pkg::FUNC_W-1:0]      func,
    input  wire logic [pts_pkg::SLOT_F_W-1:0]    slot,
    input  wire logic [pts_pkg::TMO_W-1:0]       timeout_ms,
    input  wire pts_pkg::cmd_t                   cmd,
    output pts_pkg::sts_t                        sts,
    output logic                                 expired_valid,
    output logic [pts_pkg::SLOT_F_W-1:0]         expired_slot,
    output logic                                 last,
    output logic signed [pts_pkg::NEAR_W-1:0]    nearest_ms
);
    import pts_pkg::*;

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(SLOTS - 1);

    // latched transaction
    func_t                func_reg;
    logic [SLOT_F_W-1:0]  slot_reg;
    logic [TMO_W-1:0]     tmo_reg;

    logic [TIME_BITS-1:0] now_reg;
    logic [SLOTS-1:0]     pending_reg;
    logic [TIME_BITS-1:0] deadline_mem [SLOTS];

    // scan pipeline
    logic                 issue_active_reg;
    logic [SLOT_W-1:0]    issue_idx_reg;
    logic                 v1_reg;
    logic                 last1_reg;
    logic [SLOT_W-1:0]    idx1_reg;
    logic [TIME_BITS-1:0] rd_data_reg;
    logic                 v2_reg;
    logic                 last2_reg;
    logic                 pend2_reg;
    logic [SLOT_W-1:0]    idx2_reg;
    logic [TIME_BITS-1:0] diff2_reg;
    logic                 done_reg;

    // pass results
    logic                 found_reg;
    logic [TIME_BITS-1:0] best_key_reg;
    logic [SLOT_W-1:0]    best_idx_reg;
    logic                 near_any_reg;
    logic [TIME_BITS-1:0] near_best_reg;

    // result buffer
    logic [SLOT_F_W-1:0]  res_buf_reg [RES_MAX];
    logic [RES_CNT_W-1:0] count_reg;
    logic [RES_IDX_W-1:0] out_idx_reg;

    logic                 slot_ok;
    logic                 wr_en;
    logic [SLOT_W-1:0]    slot_idx;
    logic                 due2;
    logic [TIME_BITS-1:0] key2;
    logic [TIME_BITS-1:0] clamp2;

    assign slot_ok  = (32'(slot_reg) < 32'(SLOTS));
    assign slot_idx = SLOT_W'(slot_reg);
    assign wr_en    = cmd.apply && (func_reg == FUNC_ADD) && slot_ok;

    // overdue when the wrapped difference is negative or zero
    assign due2   = diff2_reg[TIME_BITS-1] || (diff2_reg == '0);
    assign key2   = {~diff2_reg[TIME_BITS-1], diff2_reg[TIME_BITS-2:0]};
    assign clamp2 = diff2_reg[TIME_BITS-1] ? '0 : diff2_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            func_reg <= func_t'(func);
            slot_reg <= slot;
            tmo_reg  <= timeout_ms;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_reg     <= '0;
            pending_reg <= '0;
        end
        else
        begin
            if (cmd.apply)
            begin
                case (func_reg)
                    FUNC_ADD:
                    begin
                        if (slot_ok)
                        begin
                            pending_reg[slot_idx] <= 1'b1;
                        end
                    end
                    FUNC_DEL:
                    begin
                        if (slot_ok)
                        begin
                            pending_reg[slot_idx] <= 1'b0;
                        end
                    end
                    FUNC_TICK:
                    begin
                        now_reg <= now_reg + TIME_BITS'(1);
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.take)
            begin
                pending_reg[best_idx_reg] <= 1'b0;
            end
        end
    end

    // deadline memory, one write port and one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            deadline_mem[slot_idx] <= now_reg + TIME_BITS'(tmo_reg);
        end
        if (issue_active_reg)
        begin
            rd_data_reg <= deadline_mem[issue_idx_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_active_reg <= 1'b0;
            issue_idx_reg    <= '0;
            v1_reg           <= 1'b0;
            last1_reg        <= 1'b0;
            v2_reg           <= 1'b0;
            last2_reg        <= 1'b0;
            done_reg         <= 1'b0;
            found_reg        <= 1'b0;
            near_any_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.scan_start)
            begin
                issue_active_reg <= 1'b1;
                issue_idx_reg    <= '0;
            end
            else if (issue_active_reg)
            begin
                issue_idx_reg <= issue_idx_reg + SLOT_W'(1);
                if (issue_idx_reg == LAST_IDX)
                begin
                    issue_active_reg <= 1'b0;
                end
            end
            v1_reg    <= issue_active_reg;
            last1_reg <= issue_active_reg && (issue_idx_reg == LAST_IDX);
            v2_reg    <= v1_reg;
            last2_reg <= v1_reg && last1_reg;
            done_reg  <= v2_reg && last2_reg;

            if (cmd.scan_start)
            begin
                found_reg    <= 1'b0;
                near_any_reg <= 1'b0;
            end
            else if (v2_reg && pend2_reg)
            begin
                if (due2 && (!found_reg || (key2 < best_key_reg)))
                begin
                    found_reg <= 1'b1;
                end
                near_any_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx1_reg  <= issue_idx_reg;
        idx2_reg  <= idx1_reg;
        pend2_reg <= pending_reg[idx1_reg];
        diff2_reg <= rd_data_reg - now_reg;
        if (v2_reg && pend2_reg && !cmd.scan_start)
        begin
            // strict compare keeps the lower slot on equal keys
            if (due2 && (!found_reg || (key2 < best_key_reg)))
            begin
                best_key_reg <= key2;
                best_idx_reg <= idx2_reg;
            end
            if (!near_any_reg || (clamp2 < near_best_reg))
            begin
                near_best_reg <= clamp2;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            res_buf_reg[count_reg[RES_IDX_W-1:0]] <= SLOT_F_W'(best_idx_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            out_idx_reg <= '0;
        end
        else
        begin
            if (cmd.accept)
            begin
                count_reg   <= '0;
                out_idx_reg <= '0;
            end
            else
            begin
                if (cmd.take)
                begin
                    count_reg <= count_reg + RES_CNT_W'(1);
                end
                if (cmd.emit_next)
                begin
                    out_idx_reg <= out_idx_reg + RES_IDX_W'(1);
                end
            end
        end
    end

    always_comb
    begin
        sts.func      = func_reg;
        sts.scan_done = done_reg;
        sts.found     = found_reg;
        sts.buf_full  = (count_reg == RES_CNT_W'(RES_MAX - 1));
        sts.out_last  = (count_reg == '0)
                     || ({1'b0, out_idx_reg} == (count_reg - RES_CNT_W'(1)));
    end

    always_comb
    begin
        expired_valid = (count_reg != '0);
        expired_slot  = expired_valid ? res_buf_reg[out_idx_reg] : '0;
        last          = sts.out_last;
        if (!near_any_reg)
        begin
            nearest_ms = signed'(NEAR_NONE);
        end
        else if (near_best_reg > TIME_BITS'(NEAR_MAX))
        begin
            nearest_ms = signed'({1'b0, NEAR_MAX});
        end
        else
        begin
            nearest_ms = signed'({1'b0, near_best_reg[NEAR_W-2:0]});
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/per_slot_timeout_scheduler.sv
// top level of the per-slot timeout scheduler
// depends on pts_pkg, pts_ctrl and pts_dp
`default_nettype none

// Timer queue with at most one pending timeout per connection slot and a
// wrapping millisecond counter. Each input transaction carries an operation:
// add (arm slot at now + timeout_ms, replacing an older timer), delete,
// expire scan, or tick. Add, delete and tick return one result; an expire
// scan returns every due slot in deadline order (ties to the lower slot), at
// most 16, with last set on the final one, or a single invalid result when
// nothing is due. Every result carries nearest_ms, the time to the nearest
// deadline still pending after the transaction (0 when overdue, -1 when
// none). One transaction is handled at a time. Deadlines sit in a single
// memory with one read port, so every pass reads the slots one at a time;
// add, delete and tick take one such pass before their result, and an
// expire that fires k slots takes k + 1 passes before its first result
// (with 16 fired the last pass only refreshes the nearest deadline).
// Results then leave one per cycle while out_ready is high.
module per_slot_timeout_scheduler #(
    parameter int SLOTS     = 16,
    parameter int TIME_BITS = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [pts_pkg::FUNC_W-1:0]    func,
    input  wire logic [pts_pkg::SLOT_F_W-1:0]  slot,
    input  wire logic [pts_pkg::TMO_W-1:0]     timeout_ms,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic                               expired_valid,
    output logic [pts_pkg::SLOT_F_W-1:0]       expired_slot,
    output logic                               last,
    output logic signed [pts_pkg::NEAR_W-1:0]  nearest_ms
);
    import pts_pkg::*;

    // commands down to the datapath, status back up
    cmd_t cmd;
    sts_t sts;

    pts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // time counter, deadline memory, scan pipeline and result buffer
    pts_dp #(
        .SLOTS     (SLOTS),
        .TIME_BITS (TIME_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .func          (func),
        .slot          (slot),
        .timeout_ms    (timeout_ms),
        .cmd           (cmd),
        .sts           (sts),
        .expired_valid (expired_valid),
        .expired_slot  (expired_slot),
        .last          (last),
        .nearest_ms    (nearest_ms)
    );

endmodule

`default_nettype wire

>>> hw/rtl/pts_checker.sv
// port-level checks of the per-slot timeout scheduler and their bind
// depends on the top level's port list only
`default_nettype none

module pts_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic expired_valid,
    input wire logic last
);

    // no new transaction is taken while results are on offer
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input taken while results pending");

    // an invalid result is always the only one of its transaction
    a_invalid_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !expired_valid) |-> last)
        else $error("invalid result not marked last");

    // results of one transaction follow without a gap
    a_burst: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !last) |=> out_valid)
        else $error("gap inside result burst");

    // an accepted transaction needs processing before any result
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (!out_valid && !in_ready))
        else $error("result or accept right after accept");

endmodule

bind per_slot_timeout_scheduler pts_checker u_pts_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .expired_valid (expired_valid),
    .last          (last)
);

`default_nettype wire

>>> tb/tb_top.sv
// self-checking testbench for the per-slot timeout scheduler
// holds a scoreboard class with its own timer-queue predictor; drives per_slot_timeout_scheduler
// depends on pts_pkg for the operation codes and the field widths
`timescale 1ns / 100ps

module tb_top;
    import pts_pkg::*;

    localparam int TB_SLOTS     = 16;
    localparam int TB_TIME_BITS = 32;
    localparam int ITEM_TARGET  = 420;
    // cycle budget for the whole run, far above the slowest legal run
    localparam int CYCLE_LIMIT  = 1_000_000;
    // quiet period at the end, measured in whole slot passes
    localparam int QUIET_CYCLES = 4 * (TB_SLOTS + 3);
    // length of the long receiver stall used to back up the block
    localparam int RX_HOLD_CYCLES = 400;

    // one result transaction as the block should present it
    typedef struct packed {
        logic                fired;
        logic [SLOT_F_W-1:0] slot_id;
        logic                last_flag;
        logic [NEAR_W-1:0]   nearest;
    } expiry_t;

    // tracks the timer queue and checks each result against the oldest expectation
    class timer_queue_scoreboard;
        logic [TB_TIME_BITS-1:0]                    now_ms;
        logic [TB_SLOTS-1:0]                        armed;
        logic [TB_SLOTS-1:0][TB_TIME_BITS-1:0]      deadline;
        expiry_t                                    expected_q[$];
        int errors;
        int inputs_seen;
        int results_seen;
        int fired_seen;
        int biggest_scan;

        function new();
            now_ms       = '0;
            armed        = '0;
            deadline     = '0;
            errors       = 0;
            inputs_seen  = 0;
            results_seen = 0;
            fired_seen   = 0;
            biggest_scan = 0;
        endfunction

        // wrapped distance from now to a slot's deadline
        function logic [TB_TIME_BITS-1:0] gap_of(int s);
            return deadline[s] - now_ms;
        endfunction

        function logic is_due(int s);
            logic [TB_TIME_BITS-1:0] d;
            d = gap_of(s);
            return (d == '0) || d[TB_TIME_BITS-1];
        endfunction

        // time to the nearest armed deadline, 0 when overdue, all ones when idle
        function logic [NEAR_W-1:0] nearest_now();
            logic                    any;
            logic [TB_TIME_BITS-1:0] best;
            logic [TB_TIME_BITS-1:0] d;
            int                      i;
            any  = 1'b0;
            best = '0;
            for (i = 0; i < TB_SLOTS; i++) begin
                if (armed[i]) begin
                    d = gap_of(i);
                    if (d[TB_TIME_BITS-1])
                        d = '0;
                    if (!any || d < best) begin
                        best = d;
                        any  = 1'b1;
                    end
                end
            end
            if (!any)
                return NEAR_NONE;
            if (best > NEAR_MAX)
                return {1'b0, NEAR_MAX};
            return best[NEAR_W-1:0];
        endfunction

        // apply one accepted input transaction and queue the results it causes
        function void note_input(func_t op, logic [SLOT_F_W-1:0] s, logic [TMO_W-1:0] tmo);
            expiry_t                 batch[$];
            expiry_t                 r;
            logic                    found;
            logic                    done;
            int                      pick;
            int                      i;
            logic [TB_TIME_BITS-1:0] key;
            logic [TB_TIME_BITS-1:0] pkey;
            logic [NEAR_W-1:0]       near;
            inputs_seen++;
            r = '0;
            case (op)
                FUNC_ADD: begin
                    if (s < TB_SLOTS) begin
                        deadline[s] = now_ms + tmo;
                        armed[s]    = 1'b1;
                    end
                end
                FUNC_DEL: begin
                    if (s < TB_SLOTS)
                        armed[s] = 1'b0;
                end
                FUNC_TICK: begin
                    now_ms = now_ms + 1'b1;
                end
                default: begin
                    // expire: pull the earliest due slot until none is left or RES_MAX are taken
                    done = 1'b0;
                    while (!done && batch.size() < RES_MAX) begin
                        found = 1'b0;
                        pick  = 0;
                        pkey  = '0;
                        for (i = 0; i < TB_SLOTS; i++) begin
                            if (armed[i] && is_due(i)) begin
                                key = gap_of(i) ^ (1 << (TB_TIME_BITS - 1));
                                if (!found || key < pkey) begin
                                    found = 1'b1;
                                    pick  = i;
                                    pkey  = key;
                                end
                            end
                        end
                        if (!found) begin
                            done = 1'b1;
                        end else begin
                            armed[pick] = 1'b0;
                            r.fired     = 1'b1;
                            r.slot_id   = SLOT_F_W'(pick);
                            r.last_flag = 1'b0;
                            batch.push_back(r);
                        end
                    end
                    if (batch.size() > biggest_scan)
                        biggest_scan = batch.size();
                    fired_seen += batch.size();
                end
            endcase
            if (batch.size() == 0) begin
                r = '0;
                batch.push_back(r);
            end
            r           = batch.pop_back();
            r.last_flag = 1'b1;
            batch.push_back(r);
            near = nearest_now();
            while (batch.size() > 0) begin
                r         = batch.pop_front();
                r.nearest = near;
                expected_q.push_back(r);
            end
        endfunction

        function void check_result(logic v, logic [SLOT_F_W-1:0] s, logic l,
                                   logic [NEAR_W-1:0] n);
            expiry_t exp_r;
            results_seen++;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: result with nothing expected (valid %0b slot %0d last %0b)",
                         $time, v, s, l);
                return;
            end
            exp_r = expected_q.pop_front();
            if (v !== exp_r.fired) begin
                errors++;
                $display("%0t: expired_valid expected %0b actual %0b", $time, exp_r.fired, v);
            end
            if (s !== exp_r.slot_id) begin
                errors++;
                $display("%0t: expired_slot expected %0d actual %0d", $time, exp_r.slot_id, s);
            end
            if (l !== exp_r.last_flag) begin
                errors++;
                $display("%0t: last expected %0b actual %0b", $time, exp_r.last_flag, l);
            end
            if (n !== exp_r.nearest) begin
                errors++;
                $display("%0t: nearest_ms expected %0d actual %0d", $time,
                         $signed(exp_r.nearest), $signed(n));
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // anything still queued at the end never arrived
        function void close_out();
            if (expected_q.size() != 0) begin
                errors += expected_q.size();
                $display("%0t: %0d expected results never arrived", $time, expected_q.size());
            end
        endfunction
    endclass

    // clock, reset and block ports
    logic                      clk        = 1'b0;
    logic                      rst_n      = 1'b0;
    logic                      in_valid   = 1'b0;
    logic                      in_ready;
    func_t                     func       = FUNC_ADD;
    logic [SLOT_F_W-1:0]       slot       = '0;
    logic [TMO_W-1:0]          timeout_ms = '0;
    logic                      out_valid;
    logic                      out_ready  = 1'b0;
    logic                      expired_valid;
    logic [SLOT_F_W-1:0]       expired_slot;
    logic                      last;
    logic signed [NEAR_W-1:0]  nearest_ms;

    timer_queue_scoreboard board;

    // idle percentages of each side, changed per phase by the stimulus
    int tx_idle_pct = 22;
    int rx_idle_pct = 69;
    int items_sent  = 0;
    int cycle_count = 0;

    // long receiver stall: stimulus bumps the request count, receiver counts the stall
    int hold_req_cnt  = 0;
    int hold_seen_cnt = 0;
    int hold_left     = 0;

    per_slot_timeout_scheduler #(
        .SLOTS     (TB_SLOTS),
        .TIME_BITS (TB_TIME_BITS)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .func          (func),
        .slot          (slot),
        .timeout_ms    (timeout_ms),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .expired_valid (expired_valid),
        .expired_slot  (expired_slot),
        .last          (last),
        .nearest_ms    (nearest_ms)
    );

    // 8 ns period
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // watchdog on total run length
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // receiver: random back-pressure, or a long hold when the stimulus asks for one
    always @(posedge clk)
    begin
        if (hold_req_cnt != hold_seen_cnt) begin
            hold_seen_cnt = hold_req_cnt;
            hold_left     = RX_HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // monitor: values read here are the ones that were stable before the edge
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (out_valid && out_ready)
                board.check_result(expired_valid, expired_slot, last, nearest_ms);
            if (in_valid && in_ready)
                board.note_input(func, slot, timeout_ms);
        end
    end

    // offer one transaction, with random idle cycles first, and wait for acceptance
    task automatic send_op(input func_t op, input logic [SLOT_F_W-1:0] s,
                           input logic [TMO_W-1:0] tmo);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        func       <= op;
        slot       <= s;
        timeout_ms <= tmo;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
    endtask

    // stop offering and wait for every expected result to come out
    task automatic wait_until_quiet();
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    // well-formed burst: arm some distinct slots with short timeouts, maybe cancel
    // one, advance time a little, then scan once or twice; armed_cnt of 0 picks a random count
    task automatic run_expiry_burst(input int armed_cnt);
        int order[TB_SLOTS];
        int k;
        int j;
        int m;
        int tmp;
        for (j = 0; j < TB_SLOTS; j++)
            order[j] = j;
        for (j = TB_SLOTS - 1; j > 0; j--) begin
            m        = $urandom_range(0, j);
            tmp      = order[j];
            order[j] = order[m];
            order[m] = tmp;
        end
        k = (armed_cnt == 0) ? $urandom_range(1, TB_SLOTS) : armed_cnt;
        for (j = 0; j < k; j++) begin
            // mostly short timeouts so that a handful of ticks makes them due, ties included
            if ($urandom_range(9) == 0)
                send_op(FUNC_ADD, SLOT_F_W'(order[j]), TMO_W'($urandom_range(0, 40)));
            else
                send_op(FUNC_ADD, SLOT_F_W'(order[j]), TMO_W'($urandom_range(0, 8)));
        end
        if ($urandom_range(3) == 0)
            send_op(FUNC_DEL, SLOT_F_W'(order[$urandom_range(0, k - 1)]), TMO_W'($urandom));
        repeat ($urandom_range(0, 10))
            send_op(FUNC_TICK, SLOT_F_W'($urandom), TMO_W'($urandom));
        send_op(FUNC_EXPIRE, SLOT_F_W'($urandom), TMO_W'($urandom));
        if ($urandom_range(4) == 0)
            send_op(FUNC_EXPIRE, SLOT_F_W'($urandom), TMO_W'($urandom));
    endtask

    initial
    begin
        logic did_hold;
        logic did_pause;
        board     = new();
        did_hold  = 1'b0;
        did_pause = 1'b0;

        // reset held low from the start, released at an edge
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty scan, idle delete, overdue and maximal timeouts,
        // replacement, a deadline tie and cancelling an armed timer
        send_op(FUNC_EXPIRE, 4'd0, 20'd0);
        send_op(FUNC_DEL, 4'd5, 20'd0);
        send_op(FUNC_TICK, 4'd15, 20'hFFFFF);
        send_op(FUNC_ADD, 4'd0, 20'd0);
        send_op(FUNC_ADD, 4'd15, 20'hFFFFF);
        send_op(FUNC_EXPIRE, 4'd0, 20'd0);
        send_op(FUNC_ADD, 4'd3, 20'd2);
        send_op(FUNC_ADD, 4'd7, 20'd2);
        send_op(FUNC_ADD, 4'd9, 20'd1);
        send_op(FUNC_ADD, 4'd9, 20'd4);
        send_op(FUNC_TICK, 4'd0, 20'd0);
        send_op(FUNC_TICK, 4'd0, 20'd0);
        send_op(FUNC_EXPIRE, 4'd0, 20'd0);
        send_op(FUNC_DEL, 4'd15, 20'd0);
        send_op(FUNC_TICK, 4'd0, 20'd0);
        send_op(FUNC_TICK, 4'd0, 20'd0);
        send_op(FUNC_EXPIRE, 4'd0, 20'd0);
        send_op(FUNC_EXPIRE, 4'd0, 20'd0);

        // random part in three idle phases
        while (items_sent < ITEM_TARGET) begin
            if (items_sent >= 290) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end else if (items_sent >= 150) begin
                tx_idle_pct = 69;
                rx_idle_pct = 22;
            end

            if (!did_hold && items_sent >= 100) begin
                // receiver stalls while a burst arming all sixteen slots is offered,
                // so results wait and the input backs up
                did_hold = 1'b1;
                hold_req_cnt <= hold_req_cnt + 1;
                run_expiry_burst(TB_SLOTS);
            end else if (!did_pause && items_sent >= 320) begin
                // sender goes quiet until every result has drained
                did_pause = 1'b1;
                wait_until_quiet();
            end else if ($urandom_range(9) < 7) begin
                run_expiry_burst(0);
            end else begin
                // noise: any operation with fully random fields
                send_op(func_t'($urandom_range(0, 3)), SLOT_F_W'($urandom),
                        TMO_W'($urandom_range(0, 20'hFFFFF)));
            end
        end

        wait_until_quiet();
        repeat (QUIET_CYCLES) @(posedge clk);
        board.close_out();

        $display("run covered %0d transactions in and %0d results out, %0d timers fired",
                 board.inputs_seen, board.results_seen, board.fired_seen);
        $display("largest single scan fired %0d slots; mismatches %0d",
                 board.biggest_scan, board.errors);
        if (board.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
